// ----- hw/rtl/dual_bezier_easing_evaluator_unit_macros.svh -----
// assertion macros for the easing evaluator
`ifndef DUAL_BEZIER_EASING_EVALUATOR_UNIT_MACROS_SVH
`define DUAL_BEZIER_EASING_EVALUATOR_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define DBE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define DBE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define DBE_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define DBE_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/dbe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dbe_pkg;

   // signed Q2.14 value
   typedef logic signed [15:0] q_type;

   localparam int FracBits  = 14;

   // register indexes (paddr[4:3])
   localparam logic [1:0] REG_X_POINTS = 2'd0;
   localparam logic [1:0] REG_Y_POINTS = 2'd1;
   localparam logic [1:0] REG_X_COUNT  = 2'd2;
   localparam logic [1:0] REG_Y_COUNT  = 2'd3;

   // a*(1-t) + b*t, floor shift by 14, saturate to 16 bits
   function automatic q_type lerp(input q_type a, input q_type b, input q_type t);
      logic signed [16:0] wa;
      logic signed [31:0] pa;
      logic signed [31:0] pb;
      logic signed [33:0] sum;
      logic signed [19:0] shr;
      q_type              res;
      wa  = 17'sd16384 - 17'(t);
      // both products fit 32 bits signed
      pa  = 32'(a) * 32'(wa);
      pb  = 32'(b) * 32'(t);
      sum = 34'(pa) + 34'(pb);
      shr = 20'(sum >>> FracBits);
      if (shr > 20'sd32767) begin
         res = 16'sh7fff;
      end else if (shr < -20'sd32768) begin
         res = 16'sh8000;
      end else begin
         res = shr[15:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dual_bezier_easing_evaluator_unit.sv -----
// pipeline: timing curve levels, then value curve levels, from accepted t word to result word
// throughput: one word per cycle while rsp_tready does not stall, one de Casteljau level per pipeline stage
// a full pipeline holds while rsp_tready is low, bubbles are squeezed out
// reset: synchronous; clears stage valid bits and all control registers to zero
`timescale 1ns / 1ps
`default_nettype none
`include "dual_bezier_easing_evaluator_unit_macros.svh"

module dual_bezier_easing_evaluator_unit
   import dbe_pkg::*;
#(
   parameter int MAX_POINTS = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,    // [15:0] t_in
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,    // [15:0] eased_value
   // control registers
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output logic [63:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int         Levels = MAX_POINTS - 1;
   localparam int         Stages = 2 * Levels;
   localparam logic [2:0] MaxN   = 3'(MAX_POINTS);

   logic [63:0] x_points_ff;
   logic [63:0] y_points_ff;
   logic [2:0]  x_count_ff;
   logic [2:0]  y_count_ff;
   logic        csr_wr;

   // register write
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_points_ff <= '0;
         y_points_ff <= '0;
         x_count_ff  <= '0;
         y_count_ff  <= '0;
      end else if (csr_wr) begin
         unique case (csr_paddr[4:3])
            REG_X_POINTS: x_points_ff <= csr_pwdata;
            REG_Y_POINTS: y_points_ff <= csr_pwdata;
            REG_X_COUNT:  x_count_ff  <= csr_pwdata[2:0];
            REG_Y_COUNT:  y_count_ff  <= csr_pwdata[2:0];
            default:      ;
         endcase
      end
   end

   // register read
   always_comb begin
      unique case (csr_paddr[4:3])
         REG_X_POINTS: csr_prdata = x_points_ff;
         REG_Y_POINTS: csr_prdata = y_points_ff;
         REG_X_COUNT:  csr_prdata = {61'd0, x_count_ff};
         REG_Y_COUNT:  csr_prdata = {61'd0, y_count_ff};
         default:      csr_prdata = '0;
      endcase
   end

   // point counts limited to MAX_POINTS
   logic [2:0] x_n;
   logic [2:0] y_n;
   assign x_n = (x_count_ff > MaxN) ? MaxN : x_count_ff;
   assign y_n = (y_count_ff > MaxN) ? MaxN : y_count_ff;

   // pipeline registers
   logic [Stages-1:0] vld_ff;
   logic [Stages:0]   rdy;
   q_type             pt_ff [Stages][MAX_POINTS];
   q_type             t_ff  [Stages];

   assign rdy[Stages] = rsp_tready;
   assign req_tready  = rdy[0];

   for (genvar s = 0; s < Stages; s++) begin : g_stage
      localparam int Lev = s % Levels;

      q_type p_src  [MAX_POINTS];
      q_type p_in   [MAX_POINTS];
      q_type t_src;
      logic  v_src;
      logic  act;

      assign rdy[s] = !vld_ff[s] || rdy[s+1];

      // stage source: stream input, handoff to value curve, or previous stage
      if (s == 0) begin : g_first
         for (genvar j = 0; j < MAX_POINTS; j++) begin : g_ld
            assign p_src[j] = x_points_ff[16*j +: 16];
         end
         assign t_src = req_tdata;
         assign v_src = req_tvalid;
      end else if (s == Levels) begin : g_handoff
         for (genvar j = 0; j < MAX_POINTS; j++) begin : g_ld
            assign p_src[j] = y_points_ff[16*j +: 16];
         end
         assign t_src = (x_n < 3'd2) ? '0 : pt_ff[s-1][0];
         assign v_src = vld_ff[s-1];
      end else begin : g_mid
         for (genvar j = 0; j < MAX_POINTS; j++) begin : g_ld
            assign p_src[j] = pt_ff[s-1][j];
         end
         assign t_src = t_ff[s-1];
         assign v_src = vld_ff[s-1];
      end

      // level active while the curve still has points to reduce
      if (s < Levels) begin : g_xact
         assign act = (3'(Lev + 2) <= x_n);
      end else begin : g_yact
         assign act = (3'(Lev + 2) <= y_n);
      end

      // one de Casteljau level
      for (genvar j = 0; j < MAX_POINTS; j++) begin : g_lerp
         if (j < MAX_POINTS - 1) begin : g_mix
            assign p_in[j] = act ? lerp(p_src[j], p_src[j+1], t_src) : p_src[j];
         end else begin : g_keep
            assign p_in[j] = p_src[j];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (rdy[s]) begin
            vld_ff[s] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[s] && v_src) begin
            t_ff[s] <= t_src;
            for (int j = 0; j < MAX_POINTS; j++) begin
               pt_ff[s][j] <= p_in[j];
            end
         end
      end
   end

   // result word
   assign rsp_tvalid = vld_ff[Stages-1];
   assign rsp_tdata  = (y_n < 3'd2) ? '0 : pt_ff[Stages-1][0];

   // checks
   logic in_acc;
   logic out_acc;
   assign in_acc  = req_tvalid && req_tready;
   assign out_acc = rsp_tvalid && rsp_tready;

   `DBE_ASSERT_NEXT(a_words_conserved, clock, reset, 1'b1,
      ($countones(vld_ff) == $past($countones(vld_ff)) + $past(32'(in_acc)) - $past(32'(out_acc))),
      "word count in pipeline mismatch")
   `DBE_ASSERT_IMP(a_full_stall, clock, reset, (&vld_ff) && !rsp_tready, !req_tready,
      "input accepted into a stalled full pipeline")
   `DBE_ASSERT_NEXT(a_first_hold, clock, reset, vld_ff[0] && !rdy[1], vld_ff[0],
      "first stage word dropped during stall")

endmodule

`default_nettype wire

// ----- test/tb_dual_bezier_easing_evaluator_unit.sv -----
`timescale 1ns / 1ps

module tb_dual_bezier_easing_evaluator_unit;
   import dbe_pkg::*;

   localparam int MAX_POINTS     = 4;
   localparam int DRAIN_CYCLES   = 2 * (MAX_POINTS - 1) + 6;
   localparam int HOLD_CYCLES    = 200;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_WORDS    = 100;
   localparam int PRESSURE_WORDS = 60;

   // dut ports
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata   = '0;   // [15:0] t_in
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;          // [15:0] eased_value
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [4:0]  csr_paddr   = '0;
   logic [63:0] csr_pwdata  = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   // shadow copy of the control registers
   logic [63:0] x_points_shadow = '0;
   logic [63:0] y_points_shadow = '0;
   logic [2:0]  x_count_shadow  = '0;
   logic [2:0]  y_count_shadow  = '0;

   // stimulus and scoreboard
   q_type t_words_q[$];
   q_type eased_q[$];
   q_type directed_t[8];
   int    send_idle_pct  = 0;
   int    recv_stall_pct = 0;
   bit    hold_arm       = 1'b0;
   bit    hold_done      = 1'b0;
   int    hold_left      = 0;
   int    mismatches     = 0;
   int    words_sent     = 0;
   int    results_seen   = 0;
   int    curve_settings = 0;
   int    idle_cycles    = 0;

   dual_bezier_easing_evaluator_unit #(
      .MAX_POINTS(MAX_POINTS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // clock
   initial begin
      forever #1 clock = ~clock;
   end

   // one linear interpolation step in q2.14 with floor shift and saturation
   function automatic q_type lerp_q14(input q_type a, input q_type b, input q_type t);
      longint acc;
      acc = longint'(a) * (longint'(16384) - longint'(t)) + longint'(b) * longint'(t);
      acc = acc >>> 14;
      if (acc > 32767) return 16'sh7fff;
      if (acc < -32768) return 16'sh8000;
      return q_type'(acc[15:0]);
   endfunction

   // de casteljau evaluation of one packed curve
   function automatic q_type casteljau_eval(input logic [63:0] pts, input logic [2:0] cnt,
                                            input q_type t);
      q_type p[4];
      int    n;
      n = int'(cnt);
      if (n > MAX_POINTS) n = MAX_POINTS;
      if (n < 2) return '0;
      for (int i = 0; i < 4; i++) p[i] = q_type'(pts[16*i +: 16]);
      for (int i = 0; i + 1 < n; i++) begin
         for (int j = 0; j + 1 < n - i; j++) p[j] = lerp_q14(p[j], p[j+1], t);
      end
      return p[0];
   endfunction

   // timing curve then value curve
   function automatic q_type ease_value(input q_type t);
      q_type t2;
      t2 = casteljau_eval(x_points_shadow, x_count_shadow, t);
      return casteljau_eval(y_points_shadow, y_count_shadow, t2);
   endfunction

   // control points biased toward extremes and the unit interval
   function automatic q_type random_point();
      case ($urandom_range(3))
         0: begin
            case ($urandom_range(3))
               0: return 16'sh8000;
               1: return 16'sh7fff;
               2: return 16'sh0000;
               default: return 16'sh4000;
            endcase
         end
         1: return q_type'($urandom);
         default: return q_type'($urandom_range(16384));
      endcase
   endfunction

   function automatic logic [63:0] random_curve();
      return {random_point(), random_point(), random_point(), random_point()};
   endfunction

   // mostly two to four points, sometimes any 3-bit count
   function automatic logic [2:0] random_count();
      int r;
      r = $urandom_range(9);
      if (r < 7) return 3'(2 + r % 3);
      return 3'($urandom_range(7));
   endfunction

   function automatic q_type random_t();
      case ($urandom_range(3))
         0: return q_type'($urandom);
         3: begin
            case ($urandom_range(5))
               0: return 16'sh8000;
               1: return 16'sh7fff;
               2: return 16'sh0000;
               3: return 16'sh4000;
               4: return 16'shffff;
               default: return 16'sh0001;
            endcase
         end
         default: return q_type'($urandom_range(16384));
      endcase
   endfunction

   // apb write, setup then access
   task automatic csr_write(input logic [1:0] idx, input logic [63:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_X_POINTS: x_points_shadow = value;
         REG_Y_POINTS: y_points_shadow = value;
         REG_X_COUNT:  x_count_shadow  = value[2:0];
         REG_Y_COUNT:  y_count_shadow  = value[2:0];
         default: ;
      endcase
   endtask

   // counts carry random upper bits, only the low three matter
   task automatic load_curves(input logic [63:0] xp, input logic [63:0] yp,
                              input logic [2:0] xc, input logic [2:0] yc);
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      csr_write(REG_X_POINTS, xp);
      csr_write(REG_Y_POINTS, yp);
      csr_write(REG_X_COUNT, {junk[63:3], xc});
      csr_write(REG_Y_COUNT, {junk[63:3] ^ 61'h5, yc});
      curve_settings++;
   endtask

   // wait until every word is through, then let the pipeline settle
   task automatic wait_drained();
      while (t_words_q.size() != 0 || req_tvalid || eased_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      @(negedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // driver: next t word from the pending queue
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (t_words_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tdata  <= t_words_q.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // one long hold-off so the pipeline fills and stalls the input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_arm && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor: predict on accepted t words, check result words, drive ready
   always @(posedge clock) begin
      q_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            eased_q.push_back(ease_value(q_type'(req_tdata)));
            words_sent++;
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (eased_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result word %0d at %0t", $signed(rsp_tdata), $realtime);
            end else begin
               want = eased_q.pop_front();
               if (rsp_tdata !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("eased_value mismatch: expected %0d got %0d at %0t",
                              want, $signed(rsp_tdata), $realtime);
               end
            end
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", eased_q.size());
         $display("tb_dual_bezier_easing_evaluator_unit: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // phase sequencing
   initial begin
      directed_t = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh4000,
                     16'shc000, 16'sh0001, 16'shffff, 16'sh2000};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // registers at reset: both curves short, result is zero
      for (int i = 0; i < 4; i++) t_words_q.push_back(directed_t[i]);
      wait_drained();

      // full cubic curves at the extremes, saturating steps
      load_curves({16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff},
                  {16'sh4000, 16'sh0000, 16'sh7fff, 16'sh8000}, 3'd4, 3'd4);
      for (int i = 0; i < 8; i++) t_words_q.push_back(directed_t[i]);
      wait_drained();

      // short timing curve feeds zero, count above the maximum
      load_curves(64'hffff_ffff_ffff_ffff,
                  {16'shc000, 16'sh1234, 16'sh8000, 16'sh7fff}, 3'd1, 3'd7);
      for (int i = 0; i < 4; i++) t_words_q.push_back(directed_t[2*i+1]);
      wait_drained();

      // linear timing curve, short value curve gives zero
      load_curves(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 3'd2, 3'd0);
      for (int i = 0; i < 4; i++) t_words_q.push_back(directed_t[2*i]);
      wait_drained();

      // random curves under each idling mode
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         load_curves(random_curve(), random_curve(), random_count(), random_count());
         case (ph % 4)
            0: set_idling(0, 0);
            1: set_idling(48, 0);
            2: set_idling(0, 48);
            default: set_idling(12, 12);
         endcase
         for (int i = 0; i < PHASE_WORDS; i++) t_words_q.push_back(random_t());
         wait_drained();
      end

      // receiver holds off while the sender keeps offering
      load_curves(random_curve(), random_curve(), 3'd4, 3'd4);
      set_idling(0, 0);
      for (int i = 0; i < PRESSURE_WORDS; i++) t_words_q.push_back(random_t());
      hold_arm = 1'b1;
      wait_drained();

      $display("ran %0d t words through %0d curve settings, %0d eased results checked,",
               words_sent, curve_settings, results_seen);
      $display("with idle, stall and long backpressure phases; %0d mismatches", mismatches);
      if (mismatches == 0 && eased_q.size() == 0) begin
         $display("tb_dual_bezier_easing_evaluator_unit: PASS");
      end else begin
         $display("tb_dual_bezier_easing_evaluator_unit: FAIL");
      end
      $finish;
   end

endmodule
